### rtl/rkc_pkg.sv
package rkc_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_ROW_TOP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_ROW_MID    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_ROW_BOTTOM = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR          = 3'd6;

   localparam logic [10:0] IMAGE_WIDTH_RST       = 11'd1024;
   localparam logic [10:0] IMAGE_HEIGHT_RST      = 11'd1024;
   localparam logic        HAS_ALPHA_RST         = 1'b1;
   localparam logic [47:0] COEFF_ROW_TOP_RST     = 48'h0000_0001_0000;
   localparam logic [47:0] COEFF_ROW_MID_RST     = 48'h0001_0004_0001;
   localparam logic [47:0] COEFF_ROW_BOTTOM_RST  = 48'h0000_0001_0000;
   localparam logic [15:0] DIVISOR_RST           = 16'd9;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Signed width of one channel sum: nine products of 8 by 16 bits.
   localparam int SUM_W = 28;

   typedef struct packed {
      logic       op;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic       start;
      logic [15:0] divisor;
   } div_ctl_type;

endpackage

### rtl/rkc_ram.sv
module rkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rkc_div.sv
module rkc_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rkc_pkg::div_ctl_type                    ctl,
   input  logic signed [2:0][rkc_pkg::SUM_W-1:0]   sums,
   output logic                                    done,
   output logic [2:0][7:0]                         quot
);

   localparam int SW = rkc_pkg::SUM_W;
   localparam int CW = $clog2(SW + 1);

   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [2:0]           neg_ff;
   logic [2:0][15:0]     rem_ff;
   logic [2:0][SW-1:0]   num_ff;
   logic [15:0]          dvs_ff;
   logic [2:0][16:0]     trial;
   logic [2:0]           fits;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         trial[c] = {rem_ff[c], num_ff[c][SW-1]};
         fits[c]  = trial[c] >= {1'b0, dvs_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(SW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= cnt_ff != CW'(1);
         done_ff <= cnt_ff == CW'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         dvs_ff <= (ctl.divisor == '0) ? 16'd1 : ctl.divisor;
         for (int c = 0; c < 3; c++) begin
            neg_ff[c] <= sums[c][SW-1];
            num_ff[c] <= sums[c][SW-1] ? SW'(-sums[c]) : SW'(sums[c]);
            rem_ff[c] <= '0;
         end
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (fits[c]) begin
               rem_ff[c] <= 16'(trial[c] - {1'b0, dvs_ff});
            end else begin
               rem_ff[c] <= trial[c][15:0];
            end
            num_ff[c] <= {num_ff[c][SW-2:0], fits[c]};
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c] = neg_ff[c] ? 8'(-num_ff[c][7:0]) : num_ff[c][7:0];
      end
   end

   assign done = done_ff;

endmodule

### rtl/rgb_kernel_convolution_3x3.sv
// 3x3 convolution over an RGBA pixel stream in raster order.
// The req channel carries one word per pixel, or a flush word that drains
// one delayed result once the whole frame has arrived. The rsp channel
// returns one word per pixel in the same raster order; frame_last marks the
// final pixel of the frame. Results trail the input by image_width+1
// pixels, so the last image_width+1 results of a frame need flush words.
// An interior result passes through nine reads of the line store through
// its single read port, a drain and a start state, the bit-serial divider
// that works on the three channel sums at once, and the output state that
// hands the result to the rsp register. A border result takes a single read
// and the drain state and skips the divider. The next word can be taken in
// the cycle after a result is loaded, and a word that causes no result
// keeps the block idle. One word is worked on at a time; req_ready is high
// whenever no word is in progress. A finished result waits in the rsp
// output register while the next word is accepted; if the receiver stalls,
// the following result holds in its last step until the register is free.
// Reset is synchronous and restores the register defaults and the frame
// position; the line store needs no clearing. Writing image_width or
// image_height restarts the frame.
module rgb_kernel_convolution_3x3 #(
   parameter int MAX_WIDTH  = rkc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rkc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rkc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rkc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rkc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int LIN_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int AW    = $clog2(2 * MAX_WIDTH + 3);
   localparam int DEPTH = 1 << AW;
   localparam int SW    = rkc_pkg::SUM_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [10:0] width_ff, height_ff;
   logic        alpha_ff;
   logic [47:0] ctop_ff, cmid_ff, cbot_ff;
   logic [15:0] divisor_ff;

   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [LIN_W-1:0] rx_ff, rx_in, tx_ff, tx_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in, rowb_ff, rowb_in;
   logic [1:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic             interior_ff, interior_in, last_ff, last_in;
   logic             rdv_ff;
   logic [1:0]       rdr_ff, rdc_ff;
   logic [31:0]      center_ff;
   logic signed [2:0][SW-1:0] acc_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rkc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [COL_W-1:0] w;
   logic [ROW_W-1:0] h;
   logic             accept, complete, pix_wr, emit, restart, load;
   logic [LIN_W-1:0] rx_next;
   logic             lag_full, now_interior, now_last;
   logic [AW-1:0]    base;
   logic [31:0]      rdata;
   logic [47:0]      crow;
   logic signed [15:0] coef;
   logic signed [2:0][24:0] prod;
   logic [2:0][7:0]  quot;
   logic             div_done;
   rkc_pkg::div_ctl_type div_ctl;

   always_comb begin
      if (width_ff == '0) begin
         w = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w = COL_W'(MAX_WIDTH);
      end else begin
         w = COL_W'(width_ff);
      end
      if (height_ff == '0) begin
         h = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h = ROW_W'(MAX_HEIGHT);
      end else begin
         h = ROW_W'(height_ff);
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign complete  = in_row_ff >= h;
   assign pix_wr    = accept && req_data.op == rkc_pkg::OP_PIXEL && !complete;
   assign rx_next   = rx_ff + 1'b1;
   assign lag_full  = rx_next > tx_ff && (rx_next - tx_ff) > (LIN_W'(w) + 1'b1);
   assign emit      = accept && (complete || (req_data.op == rkc_pkg::OP_PIXEL && lag_full));

   assign now_interior = out_row_ff != '0 && ({1'b0, out_row_ff} + 1'b1) < {1'b0, h} &&
                         out_col_ff != '0 && ({1'b0, out_col_ff} + 1'b1) < {1'b0, w};
   assign now_last     = ({1'b0, out_row_ff} + 1'b1) >= {1'b0, h} &&
                         ({1'b0, out_col_ff} + 1'b1) >= {1'b0, w};
   assign base         = now_interior ? tx_ff[AW-1:0] - AW'(w) - 1'b1 : tx_ff[AW-1:0];

   assign restart = (emit && now_last) ||
                    (csr_we && (csr_index == rkc_pkg::CSR_IMAGE_WIDTH ||
                                csr_index == rkc_pkg::CSR_IMAGE_HEIGHT));

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      rx_in      = rx_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      tx_in      = tx_ff;
      if (pix_wr) begin
         rx_in = rx_next;
         if (({1'b0, in_col_ff} + 1'b1) >= {1'b0, w}) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      if (emit) begin
         tx_in = tx_ff + 1'b1;
         if (({1'b0, out_col_ff} + 1'b1) >= {1'b0, w}) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         rx_in      = '0;
         out_col_in = '0;
         out_row_in = '0;
         tx_in      = '0;
      end
   end

   assign load = state_ff == S_OUT && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      rd_addr_in  = rd_addr_ff;
      rowb_in     = rowb_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      interior_in = interior_ff;
      last_in     = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (emit) begin
               state_in    = S_READ;
               rd_addr_in  = base;
               rowb_in     = base;
               dx_in       = '0;
               dy_in       = '0;
               interior_in = now_interior;
               last_in     = now_last;
            end
         end
         S_READ: begin
            if (!interior_ff || (dx_ff == 2'd2 && dy_ff == 2'd2)) begin
               state_in = S_DRAIN;
            end else if (dx_ff == 2'd2) begin
               dx_in      = '0;
               dy_in      = dy_ff + 1'b1;
               rowb_in    = rowb_ff + AW'(w);
               rd_addr_in = rowb_ff + AW'(w);
            end else begin
               dx_in      = dx_ff + 1'b1;
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         S_DRAIN: state_in = interior_ff ? S_START : S_OUT;
         S_START: state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   rkc_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_line_store (
      .clock(clock),
      .we   (pix_wr),
      .waddr(rx_ff[AW-1:0]),
      .wdata({req_data.alpha_in, req_data.blue_in, req_data.green_in, req_data.red_in}),
      .re   (state_ff == S_READ),
      .raddr(rd_addr_ff),
      .rdata(rdata)
   );

   always_comb begin
      unique case (rdr_ff)
         2'd0:    crow = ctop_ff;
         2'd1:    crow = cmid_ff;
         default: crow = cbot_ff;
      endcase
      unique case (rdc_ff)
         2'd0:    coef = $signed(crow[15:0]);
         2'd1:    coef = $signed(crow[31:16]);
         default: coef = $signed(crow[47:32]);
      endcase
      for (int c = 0; c < 3; c++) begin
         prod[c] = $signed({1'b0, rdata[8*c +: 8]}) * coef;
      end
   end

   assign div_ctl.start   = state_ff == S_START;
   assign div_ctl.divisor = divisor_ff;

   rkc_div u_div (
      .clock(clock),
      .reset(reset),
      .ctl  (div_ctl),
      .sums (acc_ff),
      .done (div_done),
      .quot (quot)
   );

   always_comb begin
      rsp_data_in.frame_last = last_ff;
      if (interior_ff) begin
         rsp_data_in.red_out   = quot[0];
         rsp_data_in.green_out = quot[1];
         rsp_data_in.blue_out  = quot[2];
         rsp_data_in.alpha_out = alpha_ff ? 8'd0 : center_ff[31:24];
      end else begin
         rsp_data_in.red_out   = center_ff[7:0];
         rsp_data_in.green_out = center_ff[15:8];
         rsp_data_in.blue_out  = center_ff[23:16];
         rsp_data_in.alpha_out = center_ff[31:24];
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rx_ff        <= '0;
         tx_ff        <= '0;
         width_ff     <= rkc_pkg::IMAGE_WIDTH_RST;
         height_ff    <= rkc_pkg::IMAGE_HEIGHT_RST;
         alpha_ff     <= rkc_pkg::HAS_ALPHA_RST;
         ctop_ff      <= rkc_pkg::COEFF_ROW_TOP_RST;
         cmid_ff      <= rkc_pkg::COEFF_ROW_MID_RST;
         cbot_ff      <= rkc_pkg::COEFF_ROW_BOTTOM_RST;
         divisor_ff   <= rkc_pkg::DIVISOR_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rdv_ff       <= state_ff == S_READ;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rx_ff        <= rx_in;
         tx_ff        <= tx_in;
         if (csr_we) begin
            unique case (csr_index)
               rkc_pkg::CSR_IMAGE_WIDTH:      width_ff   <= csr_wdata[10:0];
               rkc_pkg::CSR_IMAGE_HEIGHT:     height_ff  <= csr_wdata[10:0];
               rkc_pkg::CSR_HAS_ALPHA:        alpha_ff   <= csr_wdata[0];
               rkc_pkg::CSR_COEFF_ROW_TOP:    ctop_ff    <= csr_wdata;
               rkc_pkg::CSR_COEFF_ROW_MID:    cmid_ff    <= csr_wdata;
               rkc_pkg::CSR_COEFF_ROW_BOTTOM: cbot_ff    <= csr_wdata;
               rkc_pkg::CSR_DIVISOR:          divisor_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rowb_ff     <= rowb_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      interior_ff <= interior_in;
      last_ff     <= last_in;
      rdr_ff      <= interior_ff ? dy_ff : 2'd1;
      rdc_ff      <= interior_ff ? dx_ff : 2'd1;
      if (state_ff == S_IDLE) begin
         acc_ff <= '0;
      end else if (rdv_ff && interior_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + SW'($signed(prod[c]));
         end
      end
      if (rdv_ff && rdr_ff == 2'd1 && rdc_ff == 2'd1) begin
         center_ff <= rdata;
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rkc_chk.sv
module rkc_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rkc_pkg::rsp_type rsp_data
);

   // A held result word must not change until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed or dropped while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // The block becomes busy only by taking a word.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("req_ready fell without an accepted word");

   // A new result is loaded only while the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind rgb_kernel_convolution_3x3 rkc_chk u_rkc_chk (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int RING_DEPTH = 2 * rkc_pkg::MAX_WIDTH_DEF + 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rkc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rkc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [rkc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rkc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rgb_kernel_convolution_3x3 i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state.
   logic [10:0] cfg_width = rkc_pkg::IMAGE_WIDTH_RST;
   logic [10:0] cfg_height = rkc_pkg::IMAGE_HEIGHT_RST;
   logic cfg_alpha = rkc_pkg::HAS_ALPHA_RST;
   logic [47:0] cfg_coeff [0:2] = '{rkc_pkg::COEFF_ROW_TOP_RST, rkc_pkg::COEFF_ROW_MID_RST,
                                    rkc_pkg::COEFF_ROW_BOTTOM_RST};
   logic [15:0] cfg_divisor = rkc_pkg::DIVISOR_RST;
   logic [31:0] pixel_ring [0:RING_DEPTH-1];
   int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

   rkc_pkg::req_type pending_words[$];
   rkc_pkg::rsp_type expected_pixels[$];
   int send_idle = 17, recv_idle = 79;
   int mismatches = 0;
   int words_queued = 0;
   int hold_left = 0;
   logic hold_go = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned frame_width();
      if (cfg_width == 0) return 1;
      return cfg_width > rkc_pkg::MAX_WIDTH_DEF ? rkc_pkg::MAX_WIDTH_DEF : cfg_width;
   endfunction

   function automatic int unsigned frame_height();
      if (cfg_height == 0) return 1;
      return cfg_height > rkc_pkg::MAX_HEIGHT_DEF ? rkc_pkg::MAX_HEIGHT_DEF : cfg_height;
   endfunction

   function automatic rkc_pkg::rsp_type filter_next_pixel();
      int unsigned w, h, lin;
      logic [31:0] center;
      logic [31:0] nb;
      logic interior;
      int sum, dvs;
      rkc_pkg::rsp_type r;
      w = frame_width();
      h = frame_height();
      lin = out_row * w + out_col;
      center = pixel_ring[lin % RING_DEPTH];
      interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
      r.red_out = center[7:0];
      r.green_out = center[15:8];
      r.blue_out = center[23:16];
      r.alpha_out = center[31:24];
      if (interior) begin
         dvs = cfg_divisor == 0 ? 1 : int'(cfg_divisor);
         for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int dy = 0; dy < 3; dy++) begin
               for (int dx = 0; dx < 3; dx++) begin
                  nb = pixel_ring[((out_row + dy - 1) * w + out_col + dx - 1) % RING_DEPTH];
                  sum += int'(nb[8*ch +: 8]) * int'($signed(cfg_coeff[dy][16*dx +: 16]));
               end
            end
            sum = sum / dvs;
            if (ch == 0) r.red_out = sum[7:0];
            else if (ch == 1) r.green_out = sum[7:0];
            else r.blue_out = sum[7:0];
         end
         if (cfg_alpha) r.alpha_out = 8'd0;
      end
      if (out_row + 1 >= h && out_col + 1 >= w) begin
         r.frame_last = 1'b1;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         r.frame_last = 1'b0;
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return r;
   endfunction

   function automatic bit convolve_word(input rkc_pkg::req_type it, output rkc_pkg::rsp_type r);
      int unsigned w, h, got, done;
      w = frame_width();
      h = frame_height();
      if (it.op == rkc_pkg::OP_PIXEL && in_row < h) begin
         pixel_ring[(in_row * w + in_col) % RING_DEPTH] =
            {it.alpha_in, it.blue_in, it.green_in, it.red_in};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         got = in_row * w + in_col;
         done = out_row * w + out_col;
         if (got > done && got - done > w + 1) begin
            r = filter_next_pixel();
            return 1;
         end
         return 0;
      end
      if (in_row < h) return 0;
      if (out_row * w + out_col >= h * w) return 0;
      r = filter_next_pixel();
      return 1;
   endfunction

   always @(posedge clock) begin : driver
      rkc_pkg::rsp_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (convolve_word(req_data, r)) expected_pixels.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data <= pending_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rkc_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result word %h.", rsp_data);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %h, got %h.", want, rsp_data);
               end
            end
         end
         if (hold_go) begin
            hold_left <= 400;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle;
         end
      end
   end

   task automatic write_reg(input logic [rkc_pkg::CSR_IDX_W-1:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         rkc_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width = val[10:0];
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
         rkc_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height = val[10:0];
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
         rkc_pkg::CSR_HAS_ALPHA: cfg_alpha = val[0];
         rkc_pkg::CSR_COEFF_ROW_TOP: cfg_coeff[0] = val;
         rkc_pkg::CSR_COEFF_ROW_MID: cfg_coeff[1] = val;
         rkc_pkg::CSR_COEFF_ROW_BOTTOM: cfg_coeff[2] = val;
         rkc_pkg::CSR_DIVISOR: cfg_divisor = val[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_word(input logic op, input logic [31:0] pix);
      rkc_pkg::req_type it;
      it.op = op;
      it.red_in = pix[7:0];
      it.green_in = pix[15:8];
      it.blue_in = pix[23:16];
      it.alpha_in = pix[31:24];
      pending_words.push_back(it);
      words_queued++;
   endtask

   task automatic push_frame(input int unsigned w, input int unsigned h, input bit noisy);
      int unsigned drains;
      for (int unsigned i = 0; i < w * h; i++) begin
         if (noisy && $urandom_range(19) == 0) push_word(rkc_pkg::OP_FLUSH, $urandom);
         push_word(rkc_pkg::OP_PIXEL, $urandom);
      end
      drains = w * h < w + 1 ? w * h : w + 1;
      for (int unsigned i = 0; i < drains; i++) begin
         // A pixel word after the frame is complete drains like a flush.
         if (noisy && $urandom_range(9) == 0) push_word(rkc_pkg::OP_PIXEL, $urandom);
         else push_word(rkc_pkg::OP_FLUSH, $urandom);
      end
      if (noisy && $urandom_range(3) == 0) push_word(rkc_pkg::OP_FLUSH, $urandom);
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_pace();
      if (words_queued < 420) begin
         send_idle = 17; recv_idle = 79;
      end else if (words_queued < 800) begin
         send_idle = 79; recv_idle = 17;
      end else begin
         send_idle = 0; recv_idle = 0;
      end
   endtask

   initial begin
      int unsigned w, h;
      logic [15:0] dv;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: a 4x3 frame with the default kernel, extreme pixel values.
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, 48'd4);
      write_reg(rkc_pkg::CSR_IMAGE_HEIGHT, 48'd3);
      write_reg(rkc_pkg::CSR_HAS_ALPHA, 48'd1);
      write_reg(rkc_pkg::CSR_COEFF_ROW_TOP, rkc_pkg::COEFF_ROW_TOP_RST);
      write_reg(rkc_pkg::CSR_COEFF_ROW_MID, rkc_pkg::COEFF_ROW_MID_RST);
      write_reg(rkc_pkg::CSR_COEFF_ROW_BOTTOM, rkc_pkg::COEFF_ROW_BOTTOM_RST);
      write_reg(rkc_pkg::CSR_DIVISOR, 48'd9);
      push_word(rkc_pkg::OP_FLUSH, 32'h0);
      for (int i = 0; i < 12; i++)
         push_word(rkc_pkg::OP_PIXEL, i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
      push_word(rkc_pkg::OP_PIXEL, 32'h1234_5678);
      for (int i = 0; i < 4; i++) push_word(rkc_pkg::OP_FLUSH, 32'hFFFF_FFFF);
      push_word(rkc_pkg::OP_FLUSH, 32'h0);
      wait_idle();

      // Zero geometry acts as a single pixel; extreme coefficients.
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, 48'd0);
      write_reg(rkc_pkg::CSR_IMAGE_HEIGHT, 48'd0);
      write_reg(rkc_pkg::CSR_COEFF_ROW_TOP, 48'h8000_8000_8000);
      write_reg(rkc_pkg::CSR_COEFF_ROW_MID, 48'h7FFF_7FFF_7FFF);
      write_reg(rkc_pkg::CSR_COEFF_ROW_BOTTOM, 48'hFFFF_8000_7FFF);
      write_reg(rkc_pkg::CSR_DIVISOR, 48'd0);
      write_reg(rkc_pkg::CSR_HAS_ALPHA, 48'd0);
      push_frame(1, 1, 0);
      wait_idle();
      write_reg(rkc_pkg::CSR_IMAGE_WIDTH, 48'd3);
      write_reg(rkc_pkg::CSR_IMAGE_HEIGHT, 48'd3);
      push_frame(3, 3, 0);
      wait_idle();
      write_reg(rkc_pkg::CSR_DIVISOR, 48'hFFFF);
      write_reg(rkc_pkg::CSR_HAS_ALPHA, 48'd1);
      push_frame(3, 3, 0);
      wait_idle();

      // Random frames with random settings.
      for (int phase = 0; words_queued < 1200; phase++) begin
         set_pace();
         w = $urandom_range(9) == 0 ? 0 : $urandom_range(12, 1);
         h = $urandom_range(9) == 0 ? 0 : $urandom_range(8, 1);
         if (phase == 3) begin
            w = 8;
            h = 6;
         end
         write_reg(rkc_pkg::CSR_IMAGE_WIDTH, 48'(w));
         write_reg(rkc_pkg::CSR_IMAGE_HEIGHT, 48'(h));
         write_reg(rkc_pkg::CSR_HAS_ALPHA, 48'($urandom_range(1)));
         write_reg(rkc_pkg::CSR_COEFF_ROW_TOP, 48'({$urandom, $urandom}));
         write_reg(rkc_pkg::CSR_COEFF_ROW_MID, 48'({$urandom, $urandom}));
         write_reg(rkc_pkg::CSR_COEFF_ROW_BOTTOM, 48'({$urandom, $urandom}));
         case ($urandom_range(3))
            0: dv = 16'd0;
            1: dv = 16'($urandom);
            default: dv = 16'($urandom_range(40, 1));
         endcase
         write_reg(rkc_pkg::CSR_DIVISOR, 48'(dv));
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         for (int f = $urandom_range(3, 1); f > 0; f--) push_frame(w, h, 1);
         if (phase == 3) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
